FILE: rtl/codon_to_amino_translator_top_assert.svh
// Assertion macros shared by the translator's checker.
// Each macro expands to one labeled concurrent assertion that reports with $error.
`ifndef CODON_TO_AMINO_TRANSLATOR_TOP_ASSERT_SVH
`define CODON_TO_AMINO_TRANSLATOR_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent, outside reset.
`define C2A_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent, outside reset.
`define C2A_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// The consequent must hold in the same cycle as the antecedent, reset included.
`define C2A_ASSERT_ALWAYS(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |-> (cons)) \
    else $error(msg);

`endif

FILE: rtl/c2a_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c2a_pkg
// Shared types, base-set codes and the codon pattern table of the standard
// genetic code.
// ----------------------------------------------------------------------------
package c2a_pkg;

  localparam int LETTER_W = 8;

  typedef logic [LETTER_W-1:0] letter_t;
  // Base set: bit 0 A, bit 1 C, bit 2 G, bit 3 T/U.
  typedef logic [3:0] base_set_t;

  localparam base_set_t SET_NONE = 4'b0000;
  localparam base_set_t SET_A    = 4'b0001;
  localparam base_set_t SET_C    = 4'b0010;
  localparam base_set_t SET_G    = 4'b0100;
  localparam base_set_t SET_T    = 4'b1000;
  localparam base_set_t SET_R    = SET_A | SET_G;
  localparam base_set_t SET_Y    = SET_C | SET_T;
  localparam base_set_t SET_S    = SET_C | SET_G;
  localparam base_set_t SET_W    = SET_A | SET_T;
  localparam base_set_t SET_K    = SET_G | SET_T;
  localparam base_set_t SET_M    = SET_A | SET_C;
  localparam base_set_t SET_B    = SET_C | SET_G | SET_T;
  localparam base_set_t SET_D    = SET_A | SET_G | SET_T;
  localparam base_set_t SET_H    = SET_A | SET_C | SET_T;
  localparam base_set_t SET_V    = SET_A | SET_C | SET_G;
  localparam base_set_t SET_N    = SET_A | SET_C | SET_G | SET_T;

  // Decoded codon handed from the decoder to the matcher.
  typedef struct packed {
    logic      complete;
    base_set_t first;
    base_set_t second;
    base_set_t third;
  } codon_sets_t;

  typedef struct packed {
    base_set_t pos0;
    base_set_t pos1;
    base_set_t pos2;
    letter_t   amino;
  } rule_t;

  localparam int NUM_RULES = 25;

  // Checked in order; the first matching entry wins.
  localparam rule_t RULES [NUM_RULES] = '{
    '{SET_T, SET_T, SET_Y, "F"},
    '{SET_T, SET_T, SET_R, "L"},
    '{SET_C, SET_T, SET_N, "L"},
    '{SET_T, SET_C, SET_N, "S"},
    '{SET_A, SET_G, SET_Y, "S"},
    '{SET_T, SET_A, SET_Y, "Y"},
    '{SET_T, SET_A, SET_R, "*"},
    '{SET_T, SET_G, SET_A, "*"},
    '{SET_T, SET_G, SET_Y, "C"},
    '{SET_T, SET_G, SET_G, "W"},
    '{SET_C, SET_C, SET_N, "P"},
    '{SET_C, SET_A, SET_Y, "H"},
    '{SET_C, SET_A, SET_R, "Q"},
    '{SET_C, SET_G, SET_N, "R"},
    '{SET_A, SET_G, SET_R, "R"},
    '{SET_A, SET_T, SET_H, "I"},
    '{SET_A, SET_T, SET_G, "M"},
    '{SET_A, SET_C, SET_N, "T"},
    '{SET_A, SET_A, SET_Y, "N"},
    '{SET_A, SET_A, SET_R, "K"},
    '{SET_G, SET_T, SET_N, "V"},
    '{SET_G, SET_C, SET_N, "A"},
    '{SET_G, SET_A, SET_Y, "D"},
    '{SET_G, SET_A, SET_R, "E"},
    '{SET_G, SET_G, SET_N, "G"}
  };

  // Upper-case IUPAC letter to base set; anything else is the empty set.
  function automatic base_set_t base_set(input letter_t letter);
    base_set_t s;
    unique case (letter)
      "A":     s = SET_A;
      "C":     s = SET_C;
      "G":     s = SET_G;
      "T":     s = SET_T;
      "U":     s = SET_T;
      "R":     s = SET_R;
      "Y":     s = SET_Y;
      "S":     s = SET_S;
      "W":     s = SET_W;
      "K":     s = SET_K;
      "M":     s = SET_M;
      "B":     s = SET_B;
      "D":     s = SET_D;
      "H":     s = SET_H;
      "V":     s = SET_V;
      "N":     s = SET_N;
      default: s = SET_NONE;
    endcase
    return s;
  endfunction

  // A letter fits a position when its set is non-empty and inside the allowed set.
  function automatic logic fits(input base_set_t have, input base_set_t allowed);
    return (have != SET_NONE) && ((have & ~allowed) == SET_NONE);
  endfunction

endpackage

FILE: rtl/c2a_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c2a_decode
// Turns the three ASCII letters of a codon into IUPAC base sets.
// ----------------------------------------------------------------------------
module c2a_decode
  import c2a_pkg::*;
(
  input  letter_t     base_first,
  input  letter_t     base_second,
  input  letter_t     base_third,
  input  logic        codon_complete,
  output codon_sets_t sets
);

  always_comb begin
    sets.complete = codon_complete;
    sets.first    = base_set(base_first);
    sets.second   = base_set(base_second);
    sets.third    = base_set(base_third);
  end

endmodule

FILE: rtl/c2a_match.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c2a_match
// Compares a decoded codon against all patterns in parallel and picks the
// first matching entry.
// ----------------------------------------------------------------------------
module c2a_match
  import c2a_pkg::*;
(
  input  codon_sets_t sets,
  output logic        found,
  output letter_t     amino_letter
);

  logic [NUM_RULES-1:0] hit;

  always_comb begin
    for (int i = 0; i < NUM_RULES; i++) begin
      hit[i] = sets.complete
               && fits(sets.first,  RULES[i].pos0)
               && fits(sets.second, RULES[i].pos1)
               && fits(sets.third,  RULES[i].pos2);
    end
  end

  // Walk from the last entry down so the lowest matching index is kept.
  always_comb begin
    found        = 1'b0;
    amino_letter = '0;
    for (int i = NUM_RULES - 1; i >= 0; i--) begin
      if (hit[i]) begin
        found        = 1'b1;
        amino_letter = RULES[i].amino;
      end
    end
  end

endmodule

FILE: rtl/codon_to_amino_translator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// codon_to_amino_translator_top
// Streaming translator from IUPAC nucleotide codons to amino acid letters.
// ----------------------------------------------------------------------------
// Each input transfer carries one codon as three ASCII letters and gives
// exactly one output transfer with the one-letter amino acid of the standard
// genetic code ('*' for a stop codon). IUPAC ambiguity letters are accepted:
// a codon such as "CTN" translates because every base it may stand for gives
// the same amino acid, while one that stays ambiguous, carries an unknown or
// lower-case letter, or is marked incomplete through tuser gives found = 0 and
// a zero letter. The block takes one transfer per clock cycle. Each codon is
// held in the input register, then the decode and the 25-entry priority match
// settle in front of the result register, which drives the output. Both stages
// hold their item under back-pressure and still accept a new one whenever the
// stage ahead is free, so the full rate is kept whenever the output side takes
// transfers.
// ----------------------------------------------------------------------------
module codon_to_amino_translator_top
  import c2a_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // Input stream.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // [7:0] base_first, [15:8] base_second,
                                     // [23:16] base_third
  input  logic        s_axis_tuser,  // [0] codon_complete
  // Output stream.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,  // [7:0] amino_letter
  output logic        m_axis_tuser   // [0] found
);

  // Input register stage.
  logic    in_valid;
  letter_t in_first;
  letter_t in_second;
  letter_t in_third;
  logic    in_complete;

  // Result register stage.
  logic    out_valid;
  logic    out_found;
  letter_t out_amino;

  logic    out_ready;
  logic    in_ready;

  codon_sets_t sets;
  logic        match_found;
  letter_t     match_amino;

  // A stage can load when it is empty or its item leaves in this cycle.
  assign out_ready     = !out_valid || m_axis_tready;
  assign in_ready      = !in_valid || out_ready;
  assign s_axis_tready = in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_ready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && s_axis_tvalid) begin
      in_first    <= s_axis_tdata[7:0];
      in_second   <= s_axis_tdata[15:8];
      in_third    <= s_axis_tdata[23:16];
      in_complete <= s_axis_tuser;
    end
  end

  c2a_decode u_decode (
    .base_first     (in_first),
    .base_second    (in_second),
    .base_third     (in_third),
    .codon_complete (in_complete),
    .sets           (sets)
  );

  c2a_match u_match (
    .sets         (sets),
    .found        (match_found),
    .amino_letter (match_amino)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready && in_valid) begin
      out_found <= match_found;
      out_amino <= match_amino;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_amino;
  assign m_axis_tuser  = out_found;

endmodule

FILE: rtl/c2a_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c2a_checker
// Port-level checks of the translator, attached to the top level by bind.
// ----------------------------------------------------------------------------
`include "codon_to_amino_translator_top_assert.svh"

module c2a_checker
  import c2a_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [7:0]  m_axis_tdata,
  input logic        m_axis_tuser
);

  `C2A_ASSERT_NEXT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")

  `C2A_ASSERT_SAME(a_miss_zero, clk, rst, m_axis_tvalid && !m_axis_tuser, m_axis_tdata == 8'h00, "unmatched codon gave a nonzero letter")

  `C2A_ASSERT_SAME(a_hit_letter, clk, rst, m_axis_tvalid && m_axis_tuser, (m_axis_tdata == "*") || ((m_axis_tdata >= "A") && (m_axis_tdata <= "Y")), "matched codon gave a letter outside the amino acid codes")

  // A ready output side always leaves room for a new input transfer.
  `C2A_ASSERT_SAME(a_in_ready, clk, rst, m_axis_tready, s_axis_tready, "input blocked while the output side is ready")

  `C2A_ASSERT_ALWAYS(a_reset_empty, clk, $past(rst) && !rst, !m_axis_tvalid, "result presented right after reset")

endmodule

bind codon_to_amino_translator_top c2a_checker u_c2a_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

FILE: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the codon to amino acid translator stream.
// ----------------------------------------------------------------------------
// Codons are sent in bursts of random length with random gaps between them.
// The output side stalls on a changing pattern of its own. Each accepted
// codon is translated by an independent model of the standard genetic code
// under IUPAC letters. The expected letter is queued and then compared field
// by field with the next result transfer. A directed set covers every table
// pattern, the extreme bytes, lower case, short codons and codons that are
// too ambiguous. The random part is mostly IUPAC letters with some noise.
// ----------------------------------------------------------------------------
module tb;
  import c2a_pkg::*;

  localparam int NUM_RANDOM   = 1300;
  localparam int STALL_LIMIT  = 2000;  // cycles with no transfer on either side
  localparam int DRAIN_EVERY  = 400;   // sender waits for an empty pipeline
  localparam int TAIL_CYCLES  = 8;     // pipeline is two stages deep

  // What one output transfer should carry.
  typedef struct packed {
    logic    found;
    letter_t letter;
  } amino_t;

  // One codon pattern of the standard code; the first match in table order wins.
  typedef struct packed {
    base_set_t first;
    base_set_t second;
    base_set_t third;
    letter_t   amino;
  } codon_pattern_t;

  localparam codon_pattern_t GENETIC_CODE [25] = '{
    '{SET_T, SET_T, SET_Y, "F"}, '{SET_T, SET_T, SET_R, "L"},
    '{SET_C, SET_T, SET_N, "L"}, '{SET_T, SET_C, SET_N, "S"},
    '{SET_A, SET_G, SET_Y, "S"}, '{SET_T, SET_A, SET_Y, "Y"},
    '{SET_T, SET_A, SET_R, "*"}, '{SET_T, SET_G, SET_A, "*"},
    '{SET_T, SET_G, SET_Y, "C"}, '{SET_T, SET_G, SET_G, "W"},
    '{SET_C, SET_C, SET_N, "P"}, '{SET_C, SET_A, SET_Y, "H"},
    '{SET_C, SET_A, SET_R, "Q"}, '{SET_C, SET_G, SET_N, "R"},
    '{SET_A, SET_G, SET_R, "R"}, '{SET_A, SET_T, SET_H, "I"},
    '{SET_A, SET_T, SET_G, "M"}, '{SET_A, SET_C, SET_N, "T"},
    '{SET_A, SET_A, SET_Y, "N"}, '{SET_A, SET_A, SET_R, "K"},
    '{SET_G, SET_T, SET_N, "V"}, '{SET_G, SET_C, SET_N, "A"},
    '{SET_G, SET_A, SET_Y, "D"}, '{SET_G, SET_A, SET_R, "E"},
    '{SET_G, SET_G, SET_N, "G"}
  };

  // The sixteen upper-case IUPAC letters and the bases each stands for.
  localparam letter_t IUPAC_LETTERS [16] = '{
    "A", "C", "G", "T", "U", "R", "Y", "S", "W", "K", "M", "B", "D", "H", "V", "N"
  };
  localparam base_set_t IUPAC_SETS [16] = '{
    SET_A, SET_C, SET_G, SET_T, SET_T, SET_R, SET_Y, SET_S,
    SET_W, SET_K, SET_M, SET_B, SET_D, SET_H, SET_V, SET_N
  };

  // Holds the translations of accepted codons until their results come back.
  class amino_scoreboard;
    amino_t      pending_aminos[$];
    int unsigned errors = 0;
    int unsigned codons = 0;
    int unsigned hits   = 0;
    int unsigned stops  = 0;

    static function base_set_t letter_bases(letter_t letter);
      for (int i = 0; i < 16; i++) begin
        if (IUPAC_LETTERS[i] == letter) return IUPAC_SETS[i];
      end
      return SET_NONE;
    endfunction

    // An empty set never fits; otherwise every base must be allowed.
    static function bit set_fits(base_set_t have, base_set_t allowed);
      return (have != SET_NONE) && ((have & ~allowed) == SET_NONE);
    endfunction

    static function amino_t translate(letter_t b0, letter_t b1, letter_t b2,
                                      logic complete);
      amino_t    res;
      base_set_t s0, s1, s2;
      res = '0;
      if (!complete) return res;
      s0 = letter_bases(b0);
      s1 = letter_bases(b1);
      s2 = letter_bases(b2);
      for (int r = 0; r < 25; r++) begin
        if (set_fits(s0, GENETIC_CODE[r].first) && set_fits(s1, GENETIC_CODE[r].second) &&
            set_fits(s2, GENETIC_CODE[r].third)) begin
          res.found  = 1'b1;
          res.letter = GENETIC_CODE[r].amino;
          return res;
        end
      end
      return res;
    endfunction

    function void note_codon(logic [23:0] data, logic complete);
      amino_t want;
      want = translate(data[7:0], data[15:8], data[23:16], complete);
      pending_aminos.push_back(want);
      codons++;
      if (want.found) hits++;
      if (want.found && want.letter == "*") stops++;
    endfunction

    function void check_result(logic found, letter_t letter);
      amino_t want;
      if (pending_aminos.size() == 0) begin
        $error("result with no codon waiting: found %0d, amino_letter 0x%02h",
               found, letter);
        errors++;
        return;
      end
      want = pending_aminos.pop_front();
      if (found !== want.found) begin
        $error("found: expected %0d, actual %0d", want.found, found);
        errors++;
      end
      if (letter !== want.letter) begin
        $error("amino_letter: expected 0x%02h, actual 0x%02h", want.letter, letter);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;
  logic        m_axis_tuser;

  amino_scoreboard sb = new();
  int unsigned     quiet_cycles = 0;

  // 4 ns clock period.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  codon_to_amino_translator_top u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // Both streams are sampled at the rising edge, where the values driven at
  // the previous falling edge have long settled. The input side is noted
  // first so that a codon is always queued before its own result.
  always @(posedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) sb.note_codon(s_axis_tdata, s_axis_tuser);
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tuser, m_axis_tdata);
    end
  end

  // Watchdog: a hang on either side shows up as a long run with no transfer.
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // The receiver moves between three moods: always ready, a coin toss, and
  // mostly stalled. Each mood lasts a random number of cycles, so stalls land
  // on every phase of the two pipeline stages.
  int unsigned ready_mood = 0;
  int unsigned mood_left  = 0;

  always @(negedge clk) begin
    if (mood_left == 0) begin
      ready_mood <= $urandom_range(0, 2);
      mood_left  <= $urandom_range(10, 60);
    end else begin
      mood_left <= mood_left - 1;
    end
    case (ready_mood)
      0:       m_axis_tready <= 1'b1;
      1:       m_axis_tready <= 1'($urandom_range(0, 1));
      default: m_axis_tready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  // Presents one codon from a falling edge and holds it until the transfer,
  // returning at the falling edge after it.
  task automatic send_codon(letter_t b0, letter_t b1, letter_t b2, logic complete);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {b2, b1, b0};
    s_axis_tuser  <= complete;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic pause_sender(int unsigned cycles);
    s_axis_tvalid <= 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  // Holds the sender off until every queued translation has been checked.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (sb.pending_aminos.size() != 0) @(negedge clk);
  endtask

  // Mostly real nucleotides, then other IUPAC codes, lower case, and raw bytes.
  function automatic letter_t pick_letter();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return IUPAC_LETTERS[$urandom_range(0, 4)];
    if (roll < 85) return IUPAC_LETTERS[$urandom_range(0, 15)];
    if (roll < 93) return IUPAC_LETTERS[$urandom_range(0, 15)] | 8'h20;
    return letter_t'($urandom_range(0, 255));
  endfunction

  initial begin
    int unsigned sent;
    int unsigned burst;
    int unsigned next_drain;

    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // One codon for every pattern of the table, in table order, some with
    // ambiguity letters where the pattern allows them.
    send_codon("T", "T", "Y", 1'b1);
    send_codon("T", "T", "A", 1'b1);
    send_codon("C", "T", "N", 1'b1);
    send_codon("U", "C", "N", 1'b1);
    send_codon("A", "G", "Y", 1'b1);
    send_codon("T", "A", "C", 1'b1);
    send_codon("T", "A", "R", 1'b1);
    send_codon("U", "G", "A", 1'b1);
    send_codon("T", "G", "Y", 1'b1);
    send_codon("T", "G", "G", 1'b1);
    send_codon("C", "C", "N", 1'b1);
    send_codon("C", "A", "T", 1'b1);
    send_codon("C", "A", "R", 1'b1);
    send_codon("C", "G", "N", 1'b1);
    send_codon("A", "G", "R", 1'b1);
    send_codon("A", "T", "H", 1'b1);
    send_codon("A", "U", "G", 1'b1);
    send_codon("A", "C", "N", 1'b1);
    send_codon("A", "A", "Y", 1'b1);
    send_codon("A", "A", "G", 1'b1);
    send_codon("G", "T", "N", 1'b1);
    send_codon("G", "C", "N", 1'b1);
    send_codon("G", "A", "Y", 1'b1);
    send_codon("G", "A", "R", 1'b1);
    send_codon("G", "G", "N", 1'b1);
    // Extreme bytes, lower case, a short codon, and a codon too ambiguous to
    // pin down one amino acid: none of them may translate.
    send_codon(8'h00, 8'hFF, 8'h00, 1'b1);
    send_codon(8'hFF, 8'h00, 8'hFF, 1'b1);
    send_codon("a", "t", "g", 1'b1);
    send_codon("A", "T", "G", 1'b0);
    send_codon("T", "T", "N", 1'b1);
    drain_results();

    // Random bursts. Roughly one codon in twenty is pure noise; the rest are
    // built letter by letter and nearly always marked complete.
    sent       = 0;
    next_drain = DRAIN_EVERY;
    while (sent < NUM_RANDOM) begin
      burst = $urandom_range(1, 40);
      for (int unsigned i = 0; i < burst; i++) begin
        if ($urandom_range(0, 19) == 0) begin
          send_codon(letter_t'($urandom_range(0, 255)), letter_t'($urandom_range(0, 255)),
                     letter_t'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        end else begin
          send_codon(pick_letter(), pick_letter(), pick_letter(),
                     ($urandom_range(0, 15) != 0));
        end
        sent++;
      end
      if (sent >= next_drain) begin
        drain_results();
        next_drain += DRAIN_EVERY;
      end else if ($urandom_range(0, 3) != 0) begin
        pause_sender($urandom_range(1, 12));
      end
    end

    drain_results();
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("Translated %0d codons: %0d gave an amino acid (%0d stops), %0d gave none.",
             sb.codons, sb.hits, sb.stops, sb.codons - sb.hits);
    $display("Every table pattern, unknown and short codons were sent under bursty input and output stalls.");
    if (sb.errors == 0 && sb.pending_aminos.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+rtl
rtl/c2a_pkg.sv
rtl/c2a_decode.sv
rtl/c2a_match.sv
rtl/codon_to_amino_translator_top.sv
rtl/c2a_checker.sv
tb/tb.sv
